// ===== sv/pixel_to_gray_2x2_downscale_assert.svh =====
// Assertion macros used by the port-level checker of the gray downscaler.
`ifndef PIXEL_TO_GRAY_2X2_DOWNSCALE_ASSERT_SVH
`define PIXEL_TO_GRAY_2X2_DOWNSCALE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define P2G_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gray downscaler: implication check failed");

// Next-cycle implication, disabled while reset is held.
`define P2G_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gray downscaler: next-cycle check failed");

`endif

// ===== sv/p2g_pkg.sv =====
// Package of types, constants and functions for the gray 2x2 downscaler.
package p2g_pkg;

    localparam int MaxRegionWidth  = 2048;
    localparam int MaxRegionHeight = 4096;
    localparam int ColW            = $clog2(MaxRegionWidth);
    localparam int RowW            = $clog2(MaxRegionHeight);
    localparam int StoreDepth      = (MaxRegionWidth + 1) / 2;
    localparam int AddrW           = $clog2(StoreDepth);
    localparam int SumW            = 9;
    localparam int CmpW            = 14;

    localparam logic [2:0] FmtGray8  = 3'd0;
    localparam logic [2:0] FmtBgr8   = 3'd1;
    localparam logic [2:0] FmtRgb8   = 3'd2;
    localparam logic [2:0] FmtBgra8  = 3'd3;
    localparam logic [2:0] FmtRgba8  = 3'd4;
    localparam logic [2:0] FmtRgb565 = 3'd5;

    localparam logic [1:0] CfgPixelFormat = 2'd0;
    localparam logic [1:0] CfgRegionWidth = 2'd1;
    localparam logic [1:0] CfgRegionHeight = 2'd2;

    localparam logic [2:0]  FormatReset = FmtRgb8;
    localparam logic [11:0] WidthReset  = 12'd2048;
    localparam logic [12:0] HeightReset = 13'd1024;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
    } t_in_item;

    typedef struct packed {
        logic [7:0] gray_value;
        logic       row_end;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic             emit;
        logic             sum_wr;
        logic             left_wr;
        logic             row_odd;
        logic             col_odd;
        logic             last_col;
        logic             last_row;
        logic [AddrW-1:0] addr;
    } t_stage_ctl;

    function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [15:0] acc;
        acc = 16'd77 * {8'd0, r} + 16'd150 * {8'd0, g} + 16'd29 * {8'd0, b} + 16'd128;
        return acc[15:8];
    endfunction

    function automatic logic [7:0] decode_pixel(input logic [2:0] fmt, input t_in_item px);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] c5;
        logic [7:0] res;
        r5 = px.byte_one[7:3];
        g6 = {px.byte_one[2:0], px.byte_zero[7:5]};
        c5 = px.byte_zero[4:0];
        unique case (fmt) inside
            FmtBgr8, FmtBgra8: begin
                res = luma_of(px.byte_two, px.byte_one, px.byte_zero);
            end
            FmtRgb8, FmtRgba8: begin
                res = luma_of(px.byte_zero, px.byte_one, px.byte_two);
            end
            FmtRgb565: begin
                res = luma_of({r5, r5[4:2]}, {g6, g6[5:4]}, {c5, c5[4:2]});
            end
            default: begin
                res = px.byte_zero;
            end
        endcase
        return res;
    endfunction

endpackage

// ===== sv/pixel_to_gray_2x2_downscale.sv =====
// Top level of the gray 2x2 downscaler: pixel decode, line store and block averaging.
// The block takes one pixel per clock cycle in raster order unless the output stalls and,
// when the last pixel of a 2x2 block arrives, delivers its rounded mean luma via the stage-1
// and output registers; partial blocks at an odd right or bottom edge average the samples
// present. The rate of one pixel per cycle is set by the line store, a 1024 x 9-bit memory
// with one read and one write port: the read is issued as a pixel is transferred in and the
// sum written back as it leaves stage 1, with forwarding when both touch the same entry. The
// store needs no clearing pass after reset. Configuration is to be written on its own port
// only while idle (not enforced by the block); width and height changes apply on the next pixel.
module pixel_to_gray_2x2_downscale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [12:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  p2g_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output p2g_pkg::t_out_item   o_out_data
);

    logic [2:0]  r_pixel_format;
    logic [11:0] r_region_width;
    logic [12:0] r_region_height;

    logic [p2g_pkg::ColW-1:0] r_col;
    logic [p2g_pkg::ColW-1:0] n_col;
    logic [p2g_pkg::RowW-1:0] r_row;
    logic [p2g_pkg::RowW-1:0] n_row;

    logic [p2g_pkg::SumW-1:0] r_sums [p2g_pkg::StoreDepth];
    logic [p2g_pkg::SumW-1:0] r_rd_data;
    logic                     r_fwd_hit;
    logic [p2g_pkg::SumW-1:0] r_fwd_data;

    logic                 r_s1_valid;
    logic [7:0]           r_s1_lum;
    p2g_pkg::t_stage_ctl  r_s1_ctl;
    p2g_pkg::t_stage_ctl  s0_ctl;

    logic [7:0]           r_left;
    logic                 r_out_valid;
    p2g_pkg::t_out_item   r_out;

    logic in_fire;
    logic out_free;
    logic s1_go;
    logic last_col;
    logic last_row;
    logic wr_en;
    logic [p2g_pkg::AddrW-1:0] wr_addr;
    logic [p2g_pkg::SumW-1:0]  wr_data;
    logic [p2g_pkg::SumW-1:0]  upper;
    logic [8:0]                pair_sum;
    logic [9:0]                pair_round;
    logic [9:0]                col_round;
    logic [10:0]               quad_round;
    logic [7:0]                gray;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format  <= p2g_pkg::FormatReset;
            r_region_width  <= p2g_pkg::WidthReset;
            r_region_height <= p2g_pkg::HeightReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                p2g_pkg::CfgPixelFormat:  r_pixel_format  <= i_cfg_data[2:0];
                p2g_pkg::CfgRegionWidth:  r_region_width  <= i_cfg_data[11:0];
                p2g_pkg::CfgRegionHeight: r_region_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_s1_valid && (!r_s1_ctl.emit || out_free);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_fire    = i_in_valid && o_in_ready;

    assign last_col = (p2g_pkg::CmpW'(r_col) + p2g_pkg::CmpW'(1)
                       >= p2g_pkg::CmpW'(r_region_width))
                   || (p2g_pkg::CmpW'(r_col) >= p2g_pkg::CmpW'(p2g_pkg::MaxRegionWidth - 1));
    assign last_row = (p2g_pkg::CmpW'(r_row) + p2g_pkg::CmpW'(1)
                       >= p2g_pkg::CmpW'(r_region_height))
                   || (p2g_pkg::CmpW'(r_row) >= p2g_pkg::CmpW'(p2g_pkg::MaxRegionHeight - 1));

    always_comb begin
        s0_ctl          = '0;
        s0_ctl.row_odd  = r_row[0];
        s0_ctl.col_odd  = r_col[0];
        s0_ctl.last_col = last_col;
        s0_ctl.last_row = last_row;
        s0_ctl.addr     = p2g_pkg::AddrW'(r_col >> 1);
        if (!r_row[0]) begin
            if (!r_col[0]) begin
                s0_ctl.emit    = last_col && last_row;
                s0_ctl.sum_wr  = last_col && !last_row;
                s0_ctl.left_wr = !last_col;
            end else begin
                s0_ctl.emit   = last_row;
                s0_ctl.sum_wr = !last_row;
            end
        end else begin
            if (!r_col[0]) begin
                s0_ctl.emit    = last_col;
                s0_ctl.left_wr = !last_col;
            end else begin
                s0_ctl.emit = 1'b1;
            end
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_fire) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + p2g_pkg::RowW'(1);
            end else begin
                n_col = r_col + p2g_pkg::ColW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= wr_en && (wr_addr == s0_ctl.addr);
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_lum   <= p2g_pkg::decode_pixel(r_pixel_format, i_in_data);
            r_s1_ctl   <= s0_ctl;
            r_rd_data  <= r_sums[s0_ctl.addr];
            r_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_sums[wr_addr] <= wr_data;
        end
    end

    assign upper      = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign pair_sum   = {1'b0, r_left} + {1'b0, r_s1_lum};
    assign pair_round = {1'b0, pair_sum} + 10'd1;
    assign col_round  = {1'b0, upper} + {2'b0, r_s1_lum} + 10'd1;
    assign quad_round = {2'b0, upper} + {3'b0, r_left} + {3'b0, r_s1_lum} + 11'd2;

    assign wr_en   = s1_go && r_s1_ctl.sum_wr;
    assign wr_addr = r_s1_ctl.addr;
    assign wr_data = r_s1_ctl.col_odd ? pair_sum : {1'b0, r_s1_lum};

    always_comb begin
        if (!r_s1_ctl.row_odd) begin
            gray = r_s1_ctl.col_odd ? pair_round[8:1] : r_s1_lum;
        end else begin
            gray = r_s1_ctl.col_odd ? quad_round[9:2] : col_round[8:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (s1_go && r_s1_ctl.left_wr) begin
            r_left <= r_s1_lum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_ctl.emit) begin
            r_out.gray_value <= gray;
            r_out.row_end    <= r_s1_ctl.last_col;
            r_out.frame_end  <= r_s1_ctl.last_col && r_s1_ctl.last_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/p2g_checker.sv =====
// Port-level checker for the gray 2x2 downscaler, bound to its top level.
`include "pixel_to_gray_2x2_downscale_assert.svh"

module p2g_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input p2g_pkg::t_out_item o_out_data
);

    // A result must stay put until it is transferred.
    `P2G_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // The last block of a frame always closes an output row.
    `P2G_ASSERT_IMPLY(a_frame_row, i_clk, i_rst_n, o_out_valid && o_out_data.frame_end, o_out_data.row_end)

    // With the output register empty, nothing may hold back the input.
    `P2G_ASSERT_IMPLY(a_in_free, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // Reset leaves no result pending.
    `P2G_ASSERT_IMPLY(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

endmodule

bind pixel_to_gray_2x2_downscale p2g_checker u_p2g_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the gray 2x2 downscaler, with its own luma and block-average predictor.
module tb_top;
    import p2g_pkg::*;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned SettleCycles = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [12:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;

    pixel_to_gray_2x2_downscale dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state, mirroring the registers, counters and line store of the block.
    logic [2:0]  fmt_reg    = FormatReset;
    logic [11:0] reg_width  = WidthReset;
    logic [12:0] reg_height = HeightReset;
    int unsigned col_cnt    = 0;
    int unsigned row_cnt    = 0;
    int unsigned left_luma  = 0;
    logic [8:0]  line_sums [StoreDepth];

    t_out_item   gray_expected [$];
    int unsigned errors         = 0;
    int unsigned results_checked = 0;
    int unsigned pixels_sent    = 0;
    int unsigned frames_done    = 0;
    int unsigned cycles         = 0;
    int unsigned hold_request   = 0;
    bit          send_idle      = 1'b0;
    bit          recv_idle      = 1'b0;

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned top);
        return (v == 0) ? 1 : ((v > top) ? top : v);
    endfunction

    function automatic int unsigned pixel_luma(input logic [2:0] pix_fmt, input t_in_item px);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        logic [15:0] word565;
        word565 = {px.byte_one, px.byte_zero};
        case (pix_fmt)
            FmtBgr8, FmtBgra8: begin
                r = px.byte_two;
                g = px.byte_one;
                b = px.byte_zero;
            end
            FmtRgb8, FmtRgba8: begin
                r = px.byte_zero;
                g = px.byte_one;
                b = px.byte_two;
            end
            FmtRgb565: begin
                r = {word565[15:11], word565[15:13]};
                g = {word565[10:5], word565[10:9]};
                b = {word565[4:0], word565[4:2]};
            end
            default: begin
                return px.byte_zero;
            end
        endcase
        return (77 * r + 150 * g + 29 * b + 128) >> 8;
    endfunction

    function automatic logic predict_pixel(input t_in_item px, output t_out_item res);
        int unsigned w;
        int unsigned h;
        int unsigned lum;
        int unsigned slot;
        int unsigned upper;
        int unsigned gray;
        int unsigned pair;
        logic        last_c;
        logic        last_r;
        logic        emit;
        w      = clamp_size(reg_width, MaxRegionWidth);
        h      = clamp_size(reg_height, MaxRegionHeight);
        lum    = pixel_luma(fmt_reg, px);
        last_c = (col_cnt >= w - 1);
        last_r = (row_cnt >= h - 1);
        slot   = col_cnt >> 1;
        upper  = (slot < StoreDepth) ? line_sums[slot] : 0;
        emit   = 1'b0;
        gray   = 0;
        if (row_cnt[0] == 1'b0) begin
            if (col_cnt[0] == 1'b0) begin
                if (!last_c) begin
                    left_luma = lum;
                end else if (last_r) begin
                    gray = lum;
                    emit = 1'b1;
                end else if (slot < StoreDepth) begin
                    line_sums[slot] = lum[8:0];
                end
            end else begin
                pair = left_luma + lum;
                if (last_r) begin
                    gray = (pair + 1) >> 1;
                    emit = 1'b1;
                end else if (slot < StoreDepth) begin
                    line_sums[slot] = pair[8:0];
                end
            end
        end else begin
            if (col_cnt[0] == 1'b0) begin
                if (last_c) begin
                    gray = (upper + lum + 1) >> 1;
                    emit = 1'b1;
                end else begin
                    left_luma = lum;
                end
            end else begin
                gray = (upper + left_luma + lum + 2) >> 2;
                emit = 1'b1;
            end
        end
        if (last_c) begin
            col_cnt = 0;
            row_cnt = last_r ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
        res.gray_value = gray[7:0];
        res.row_end    = last_c;
        res.frame_end  = last_c & last_r;
        return emit;
    endfunction

    // Writes one register; the valid is lowered only after the last write of a group.
    task automatic write_reg(input logic [1:0] idx, input logic [12:0] value, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CfgPixelFormat:  fmt_reg = value[2:0];
            CfgRegionWidth:  reg_width = value[11:0];
            CfgRegionHeight: reg_height = value;
            default: ;
        endcase
        @(negedge i_clk);
        if (last) begin
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic send_pixel(input t_in_item px);
        int unsigned gap;
        t_out_item   res;
        gap = send_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_pixel(px, res)) begin
            gray_expected.insert(gray_expected.size(), res);
        end
        pixels_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_in_item random_pixel();
        logic [31:0] r;
        r = $urandom;
        return r[23:0];
    endfunction

    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (gray_expected.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic run_frame(input logic [2:0] pf, input logic [12:0] w_data,
                             input logic [12:0] h_data);
        int unsigned npix;
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
        write_reg(CfgPixelFormat, {10'd0, pf}, 1'b0);
        write_reg(CfgRegionWidth, w_data, 1'b0);
        write_reg(CfgRegionHeight, h_data, 1'b1);
        npix = clamp_size(w_data[11:0], MaxRegionWidth) * clamp_size(h_data, MaxRegionHeight);
        repeat (npix) send_pixel(random_pixel());
        finish_phase();
        frames_done++;
    endtask

    // A zero-sized region acts as one pixel, so every pixel gives its own luma.
    task automatic test_format_decode();
        int         k;
        logic [2:0] f;
        write_reg(CfgRegionWidth, 13'd0, 1'b0);
        write_reg(CfgRegionHeight, 13'd0, 1'b1);
        send_pixel('1);
        finish_phase();
        for (k = 0; k < 8; k++) begin
            f = k[2:0];
            write_reg(CfgPixelFormat, {10'd0, f}, 1'b1);
            send_pixel('1);
            if (f == FmtGray8) begin
                send_pixel('0);
            end
            if (f == FmtRgb565) begin
                send_pixel(t_in_item'{byte_zero: 8'h5a, byte_one: 8'ha5, byte_two: 8'h00});
            end
            finish_phase();
        end
    endtask

    task automatic test_partial_blocks();
        run_frame(FmtGray8, 13'd3, 13'd3);
    endtask

    // Shrinking the region mid-frame makes the pending pixel the last of its row or frame.
    task automatic test_counter_overrun();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        write_reg(CfgPixelFormat, {10'd0, FmtGray8}, 1'b0);
        write_reg(CfgRegionWidth, 13'd4, 1'b0);
        write_reg(CfgRegionHeight, 13'd2, 1'b1);
        repeat (3) send_pixel(random_pixel());
        finish_phase();
        write_reg(CfgRegionWidth, 13'd2, 1'b1);
        repeat (3) send_pixel(random_pixel());
        finish_phase();
        write_reg(CfgRegionWidth, 13'd1, 1'b0);
        write_reg(CfgRegionHeight, 13'd4, 1'b1);
        repeat (3) send_pixel(random_pixel());
        finish_phase();
        write_reg(CfgRegionHeight, 13'd2, 1'b1);
        send_pixel(random_pixel());
        finish_phase();
    endtask

    task automatic test_extreme_sizes();
        run_frame(3'($urandom_range(0, 7)), 13'd0, 13'd5);
        run_frame(3'($urandom_range(0, 7)), 13'd33, 13'd0);
        run_frame(3'($urandom_range(0, 7)), 13'd0, 13'd0);
    endtask

    task automatic test_backpressure();
        hold_request = 200;
        run_frame(3'($urandom_range(0, 7)), 13'd8, 13'd8);
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int unsigned pick;
        logic [12:0] w_data;
        logic [12:0] h_data;
        start = pixels_sent;
        while (pixels_sent - start < 580) begin
            pick = $urandom_range(0, 15);
            w_data = (pick == 0) ? 13'd0 :
                     (pick == 1) ? 13'($urandom_range(11, 24)) : 13'($urandom_range(1, 10));
            pick = $urandom_range(0, 15);
            h_data = (pick == 0) ? 13'd0 :
                     (pick == 1) ? 13'($urandom_range(9, 16)) : 13'($urandom_range(1, 8));
            run_frame(3'($urandom_range(0, 7)), w_data, h_data);
        end
    endtask

    initial begin
        int unsigned gap;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = (hold_request > 0) ? hold_request : (recv_idle ? $urandom_range(0, 3) : 0);
            hold_request = 0;
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready) && hold_request == 0);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (gray_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual gray %0d", $time,
                         o_out_data.gray_value);
                errors++;
            end else begin
                want = gray_expected.pop_front();
                results_checked++;
                if (o_out_data.gray_value !== want.gray_value) begin
                    $display("%0t: gray_value expected %0d, actual %0d", $time,
                             want.gray_value, o_out_data.gray_value);
                    errors++;
                end
                if (o_out_data.row_end !== want.row_end) begin
                    $display("%0t: row_end expected %0b, actual %0b", $time,
                             want.row_end, o_out_data.row_end);
                    errors++;
                end
                if (o_out_data.frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %0b, actual %0b", $time,
                             want.frame_end, o_out_data.frame_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CfgPixelFormat;
        i_cfg_data  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_format_decode();
        test_partial_blocks();
        test_counter_overrun();
        test_extreme_sizes();
        test_backpressure();
        test_random_frames();
        while (gray_expected.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        errors += gray_expected.size();
        $display("Sent %0d pixels in %0d frames over all format codes, zero and odd region",
                 pixels_sent, frames_done);
        $display("sizes, mid-frame shrinks and a long output stall; checked %0d gray results.",
                 results_checked);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
